>>> rtl/bsa_pkg.sv
`timescale 1ns / 1ps
package bsa_pkg;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_NUM_LABELS = 256;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [10:0] RESET_WIDTH  = 11'd640;
  localparam logic [10:0] RESET_HEIGHT = 11'd480;

  localparam int SUM_W  = 31;
  localparam int CNT_W  = 21;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  pixel_label;
    logic [7:0]  query_label;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  blob_label;
    logic [20:0] area;
    logic [20:0] perimeter;
    logic [9:0]  box_left;
    logic [9:0]  box_top;
    logic signed [11:0] box_width;
    logic signed [11:0] box_height;
    logic [9:0]  centroid_x;
    logic [9:0]  centroid_y;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clr_start;   // load sweep counter, reset frame
    logic clr_step;    // write one store entry
    logic pix;         // push pixel, read stores for centre
    logic upd;         // write back centre statistics
    logic rd_start;    // read one entry
    logic div_start;   // load the dividers
    logic div_step;    // one quotient bit
    logic out_load;    // capture result
  } bsa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
  } bsa_sts_t;
endpackage

>>> rtl/bsa_stream_if.sv
`timescale 1ns / 1ps
interface bsa_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/bsa_cfg_if.sv
`timescale 1ns / 1ps
interface bsa_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [10:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/blob_statistics_accumulator.sv
`timescale 1ns / 1ps
// Label image statistics accumulator.
// in: opcode, pixel_label, query_label. opcode clear wipes all label entries
// and restarts the frame; pixel pushes the next raster pixel; read returns one
// label's area, perimeter, bounding box and centroid on out.
// cfg: index 0 writes the image width, index 1 the height; write only while
// idle. Sizes are clamped to 3..MAX_WIDTH / MAX_HEIGHT.
// For a pixel, the store entry of the centre label is read in one cycle and
// written back in the next, so no new pixel is taken before that write back.
// A read fetches the entry and then runs a 31-step restoring divider, one
// quotient bit of each axis per cycle.
// A clear sweeps all NUM_LABELS store entries, one store entry written per cycle.
// After reset the same sweep runs, with in_ready low.
// A result waits in the output register while out_ready is low; pixels are
// still taken meanwhile, and a further read runs but loads only once it has left.
module blob_statistics_accumulator
  import bsa_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int NUM_LABELS = DEF_NUM_LABELS
) (
  input logic clk,
  input logic rst_n,
  bsa_stream_if.sink   in_ch,
  bsa_stream_if.source out_ch,
  bsa_cfg_if.sink      cfg_ch
);
  logic [10:0] width_r, height_r;
  bsa_cmd_t    cmd;
  bsa_sts_t    sts;
  in_item_t    in_item;
  out_item_t   result;
  logic        out_valid_r;

  assign in_item = in_ch.data;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_WIDTH) width_r <= cfg_ch.wdata;
      else height_r <= cfg_ch.wdata;
    end
  end

  bsa_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_opcode(in_item.opcode),
    .out_valid(out_valid_r),
    .out_ready(out_ch.ready),
    .sts, .cmd
  );

  bsa_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .NUM_LABELS(NUM_LABELS)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .pixel_label(in_item.pixel_label),
    .query_label(in_item.query_label),
    .result
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = result;
endmodule

>>> rtl/bsa_ctrl.sv
`timescale 1ns / 1ps
module bsa_ctrl
  import bsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic       out_valid,
  input  logic       out_ready,
  input  bsa_sts_t   sts,
  output bsa_cmd_t   cmd
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       acc;

  // the output register may still be full when a pixel comes in
  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          priority if (in_opcode == OP_CLEAR) begin
            cmd.clr_start = 1'b1;
            state_nxt = S_CLR;
          end else if (in_opcode == OP_PIXEL) begin
            cmd.pix = 1'b1;
            state_nxt = S_UPD;
          end else if (in_opcode == OP_READ) begin
            cmd.rd_start = 1'b1;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

  a_clr_after_reset: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> !in_ready)
    else $error("input taken during clearing sweep");
  a_pix_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pix |=> cmd.upd)
    else $error("pixel without write back");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten");
endmodule

>>> rtl/bsa_datapath.sv
`timescale 1ns / 1ps
module bsa_datapath
  import bsa_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int NUM_LABELS = DEF_NUM_LABELS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  bsa_cmd_t    cmd,
  output bsa_sts_t    sts,
  input  logic [10:0] width_cfg,
  input  logic [10:0] height_cfg,
  input  logic [7:0]  pixel_label,
  input  logic [7:0]  query_label,
  output out_item_t   result
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int LW = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
  localparam int BW = 2 * XW + 2 * YW;

  // effective size, clamped
  logic [12:0] wq, hq;
  logic [12:0] w_eff, h_eff;
  always_comb begin
    wq = {2'b0, width_cfg};
    hq = {2'b0, height_cfg};
    if (wq < 13'd3) w_eff = 13'd3;
    else if (wq > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
    else w_eff = wq;
    if (hq < 13'd3) h_eff = 13'd3;
    else if (hq > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
    else h_eff = hq;
  end
  logic [XW-1:0] wm1;
  logic [YW-1:0] hm1;
  assign wm1 = XW'(w_eff - 13'd1);
  assign hm1 = YW'(h_eff - 13'd1);

  // label stores
  logic [CNT_W-1:0] area_mem [NUM_LABELS];
  logic [CNT_W-1:0] per_mem  [NUM_LABELS];
  logic [SUM_W-1:0] sx_mem   [NUM_LABELS];
  logic [SUM_W-1:0] sy_mem   [NUM_LABELS];
  logic [BW-1:0]    box_mem  [NUM_LABELS];
  logic [7:0]       lbu [MAX_WIDTH];
  logic [7:0]       lbm [MAX_WIDTH];

  logic [XW:0] col_r;
  logic [YW:0] row_r;
  logic [7:0]  win_r [6];
  logic [LW:0] clr_r;

  // centre pipeline
  logic           ju_r;
  logic [7:0]     cl_r;
  logic [XW-1:0]  cx_r;
  logic [YW-1:0]  cy_r;
  logic           edge_r;
  logic [CNT_W-1:0] ra_r, rp_r;
  logic [SUM_W-1:0] rsx_r, rsy_r;
  logic [BW-1:0]    rb_r;

  // line buffer read data and the pixel waiting for its write back
  logic [7:0]     top_r, mid_r, pl_r;
  logic [XW-1:0]  pc_r;

  logic [XW-1:0] c;
  logic [YW-1:0] r;
  always_comb begin
    c = (col_r >= (XW+1)'(w_eff)) ? '0 : col_r[XW-1:0];
    r = (row_r >= (YW+1)'(h_eff)) ? '0 : row_r[YW-1:0];
  end

  logic [LW-1:0] cidx;
  assign cidx = win_r[4][LW-1:0];

  logic judge;
  assign judge = (c >= XW'(2)) && (r >= YW'(2)) && (win_r[4] != 8'd0)
                 && ({1'b0, win_r[4]} < 9'(NUM_LABELS));

  logic [XW:0] col_inc;
  assign col_inc = {1'b0, c} + 1'b1;

  // right neighour only arrives with the line buffer read
  logic edge_w;
  assign edge_w = edge_r || (mid_r != cl_r);

  always_ff @(posedge clk) begin
    if (cmd.pix) begin
      top_r <= lbu[c];
      mid_r <= lbm[c];
    end
    if (cmd.upd) begin
      lbu[pc_r] <= mid_r;
      lbm[pc_r] <= pl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix) begin
      pl_r  <= pixel_label;
      pc_r  <= c;
      ra_r  <= area_mem[cidx];
      rp_r  <= per_mem[cidx];
      rsx_r <= sx_mem[cidx];
      rsy_r <= sy_mem[cidx];
      rb_r  <= box_mem[cidx];
      cl_r  <= win_r[4];
      cx_r  <= c - 1'b1;
      cy_r  <= r - 1'b1;
      edge_r <= (win_r[3] != win_r[4]) || (win_r[1] != win_r[4]) ||
                (win_r[5] != win_r[4]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ju_r <= 1'b0;
    end else begin
      ju_r <= cmd.pix && judge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_start) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else begin
      if (cmd.pix) begin
        if (col_inc >= (XW+1)'(w_eff)) begin
          col_r <= '0;
          row_r <= ({1'b0, r} + 1'b1 >= (YW+1)'(h_eff)) ? '0 : {1'b0, r} + 1'b1;
        end else begin
          col_r <= col_inc;
          row_r <= {1'b0, r};
        end
      end
      if (cmd.upd) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= top_r;
        win_r[4] <= mid_r;
        win_r[5] <= pl_r;
      end
    end
  end

  // write back or clear sweep
  logic [XW-1:0] bminx, bmaxx;
  logic [YW-1:0] bminy, bmaxy;
  logic [LW-1:0] widx;
  always_comb begin
    {bminx, bminy, bmaxx, bmaxy} = rb_r;
    if (bminx > cx_r) bminx = cx_r;
    if (bminy > cy_r) bminy = cy_r;
    if (bmaxx < cx_r) bmaxx = cx_r;
    if (bmaxy < cy_r) bmaxy = cy_r;
    widx = cl_r[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      area_mem[clr_r[LW-1:0]] <= '0;
      per_mem[clr_r[LW-1:0]]  <= '0;
      sx_mem[clr_r[LW-1:0]]   <= '0;
      sy_mem[clr_r[LW-1:0]]   <= '0;
      box_mem[clr_r[LW-1:0]]  <= {wm1, hm1, XW'(0), YW'(0)};
    end else if (cmd.upd && ju_r) begin
      area_mem[widx] <= ra_r + 1'b1;
      per_mem[widx]  <= rp_r + CNT_W'(edge_w);
      sx_mem[widx]   <= rsx_r + SUM_W'(cx_r);
      sy_mem[widx]   <= rsy_r + SUM_W'(cy_r);
      box_mem[widx]  <= {bminx, bminy, bmaxx, bmaxy};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_start) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + 1'b1;
  end
  assign sts.clr_last = (clr_r == (LW+1)'(NUM_LABELS - 1));

  // read and restoring division, one quotient bit per cycle for both axes
  logic [CNT_W-1:0] qa_r, qp_r;
  logic [BW-1:0]    qb_r;
  logic [SUM_W-1:0] qx_r, qy_r;
  logic [7:0]       ql_r;
  logic [SUM_W-1:0] nx_r, ny_r;
  logic [CNT_W:0]   remx_r, remy_r;
  logic [4:0]       dcnt_r;
  logic [CNT_W-1:0] dv;
  logic             qvalid;
  assign qvalid = {1'b0, query_label} < 9'(NUM_LABELS);
  assign dv = (qa_r == '0) ? CNT_W'(1) : qa_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      ql_r <= query_label;
      if (qvalid) begin
        qa_r <= area_mem[query_label[LW-1:0]];
        qp_r <= per_mem[query_label[LW-1:0]];
        qx_r <= sx_mem[query_label[LW-1:0]];
        qy_r <= sy_mem[query_label[LW-1:0]];
        qb_r <= box_mem[query_label[LW-1:0]];
      end else begin
        qa_r <= '0;
        qp_r <= '0;
        qx_r <= '0;
        qy_r <= '0;
        qb_r <= {wm1, hm1, XW'(0), YW'(0)};
      end
    end
  end

  logic [CNT_W:0] tx, ty;
  always_comb begin
    tx = {remx_r[CNT_W-1:0], nx_r[SUM_W-1]};
    ty = {remy_r[CNT_W-1:0], ny_r[SUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      nx_r <= qx_r;
      ny_r <= qy_r;
      remx_r <= '0;
      remy_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (tx >= {1'b0, dv}) begin
        remx_r <= tx - {1'b0, dv};
        nx_r <= {nx_r[SUM_W-2:0], 1'b1};
      end else begin
        remx_r <= tx;
        nx_r <= {nx_r[SUM_W-2:0], 1'b0};
      end
      if (ty >= {1'b0, dv}) begin
        remy_r <= ty - {1'b0, dv};
        ny_r <= {ny_r[SUM_W-2:0], 1'b1};
      end else begin
        remy_r <= ty;
        ny_r <= {ny_r[SUM_W-2:0], 1'b0};
      end
    end
  end
  assign sts.div_last = (dcnt_r == 5'(SUM_W - 1));

  logic [XW-1:0] ominx, omaxx;
  logic [YW-1:0] ominy, omaxy;
  assign {ominx, ominy, omaxx, omaxy} = qb_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.blob_label <= ql_r;
      result.area       <= qa_r;
      result.perimeter  <= qp_r;
      result.box_left   <= 10'(ominx);
      result.box_top    <= 10'(ominy);
      result.box_width  <= 12'(13'(omaxx) - 13'(ominx) + 13'd1);
      result.box_height <= 12'(13'(omaxy) - 13'(ominy) + 13'd1);
      result.centroid_x <= nx_r[9:0];
      result.centroid_y <= ny_r[9:0];
    end
  end
endmodule
